/* rtl/frts_pkg.sv */
// ----------------------------------------------------------------------------
// Face region template scorer package
// Shared types, register indexes, reciprocal constants and the region
// bound calculation used by the configuration and front-end modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package frts_pkg;

  localparam int unsigned DIM_W     = 10;
  localparam int unsigned POS_W     = 11;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned SCORE_W   = 22;
  localparam int unsigned SCORE_O_W = 21;
  localparam int unsigned THR_W     = 25;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned QDEPTH    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = 4'd3;

  localparam logic [DIM_W-1:0] RST_ORIGIN_X      = 10'd0;
  localparam logic [DIM_W-1:0] RST_ORIGIN_Y      = 10'd0;
  localparam logic [DIM_W-1:0] RST_WINDOW_WIDTH  = 10'd160;
  localparam logic [DIM_W-1:0] RST_WINDOW_HEIGHT = 10'd240;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // Reciprocals: ceil(2^16 / 7) and ceil(2^16 / 5).
  localparam logic [13:0] RECIP7 = 14'd9363;
  localparam logic [13:0] RECIP5 = 14'd13108;

  typedef enum logic [1:0] {
    DELTA_NONE,
    DELTA_PLUS,
    DELTA_MINUS
  } frts_delta_e;

  typedef struct packed {
    logic [DIM_W-1:0] origin_x;
    logic [DIM_W-1:0] origin_y;
    logic [DIM_W-1:0] cx1;
    logic [DIM_W-1:0] cx3;
    logic [DIM_W-1:0] cx4;
    logic [DIM_W-1:0] cx6;
    logic [DIM_W-1:0] ry1;
    logic [DIM_W-1:0] ry2;
    logic [DIM_W-1:0] ry3;
    logic [DIM_W-1:0] ry4;
    logic [DIM_W-1:0] col_last;
    logic [DIM_W-1:0] row_last;
  } frts_geom_t;

  typedef struct packed {
    logic [POS_W-1:0] pixel_x;
    logic [POS_W-1:0] pixel_y;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             last;
    frts_delta_e      delta;
  } frts_item_t;

  function automatic logic [DIM_W-1:0] frts_div7(input logic [12:0] n);
    logic [26:0] p;
    p = 27'(n) * 27'(RECIP7);
    return p[25:16];
  endfunction

  function automatic logic [DIM_W-1:0] frts_div5(input logic [10:0] n);
    logic [25:0] p;
    p = 26'(n) * 26'(RECIP5);
    return p[25:16];
  endfunction

  function automatic logic [DIM_W-1:0] frts_div10(input logic [12:0] n);
    logic [26:0] p;
    p = 27'(n) * 27'(RECIP5);
    return p[26:17];
  endfunction

  function automatic logic [DIM_W-1:0] frts_div20(input logic [13:0] n);
    logic [27:0] p;
    p = 28'(n) * 28'(RECIP5);
    return p[27:18];
  endfunction

  // A zero dimension is taken as one.
  function automatic frts_geom_t frts_geom_calc(input logic [DIM_W-1:0] ox,
                                                input logic [DIM_W-1:0] oy,
                                                input logic [DIM_W-1:0] w,
                                                input logic [DIM_W-1:0] h);
    frts_geom_t       g;
    logic [DIM_W-1:0] we;
    logic [DIM_W-1:0] he;
    we = (w == '0) ? DIM_W'(1) : w;
    he = (h == '0) ? DIM_W'(1) : h;
    g.origin_x = ox;
    g.origin_y = oy;
    g.cx1      = frts_div7(13'(we));
    g.cx3      = frts_div7(13'(we) * 13'd3);
    g.cx4      = frts_div7(13'(we) * 13'd4);
    g.cx6      = frts_div7(13'(we) * 13'd6);
    g.ry1      = frts_div5(11'(he));
    g.ry2      = frts_div5(11'(he) * 11'd2);
    g.ry3      = frts_div20(14'(he) * 14'd11);
    g.ry4      = frts_div10(13'(he) * 13'd7);
    g.col_last = we - DIM_W'(1);
    g.row_last = he - DIM_W'(1);
    return g;
  endfunction

endpackage

`default_nettype wire

/* rtl/frts_cfg.sv */
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the window registers, registers the region bounds derived from
// them and forms the scaled face threshold 13 * area over two more stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frts_cfg
  import frts_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DIM_W-1:0]     cfg_wdata_i,
  output frts_geom_t                geom_o,
  output logic [THR_W-1:0]          thr_o
);

  logic [DIM_W-1:0] origin_x_q, origin_x_d;
  logic [DIM_W-1:0] origin_y_q, origin_y_d;
  logic [DIM_W-1:0] width_q, width_d;
  logic [DIM_W-1:0] height_q, height_d;
  frts_geom_t       geom_q;
  logic [19:0]      eye_area_q, eye_area_d;
  logic [19:0]      mouth_area_q, mouth_area_d;
  logic [THR_W-1:0] thr_q, thr_d;

  always_comb begin
    origin_x_d = origin_x_q;
    origin_y_d = origin_y_q;
    width_d    = width_q;
    height_d   = height_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ORIGIN_X:      origin_x_d = cfg_wdata_i;
        CFG_ORIGIN_Y:      origin_y_d = cfg_wdata_i;
        CFG_WINDOW_WIDTH:  width_d    = cfg_wdata_i;
        CFG_WINDOW_HEIGHT: height_d   = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    eye_area_d   = 20'(geom_q.ry2 - geom_q.ry1) * 20'(geom_q.cx3 - geom_q.cx1);
    mouth_area_d = 20'(geom_q.ry4 - geom_q.ry3) * 20'(geom_q.cx6 - geom_q.cx1);
    thr_d        = THR_W'(21'(eye_area_q) + 21'(mouth_area_q)) * THR_W'(13);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= RST_ORIGIN_X;
      origin_y_q <= RST_ORIGIN_Y;
      width_q    <= RST_WINDOW_WIDTH;
      height_q   <= RST_WINDOW_HEIGHT;
      geom_q     <= frts_geom_calc(RST_ORIGIN_X, RST_ORIGIN_Y,
                                   RST_WINDOW_WIDTH, RST_WINDOW_HEIGHT);
    end else begin
      origin_x_q <= origin_x_d;
      origin_y_q <= origin_y_d;
      width_q    <= width_d;
      height_q   <= height_d;
      geom_q     <= frts_geom_calc(origin_x_d, origin_y_d, width_d, height_d);
    end
  end

  always_ff @(posedge clk_i) begin
    eye_area_q   <= eye_area_d;
    mouth_area_q <= mouth_area_d;
    thr_q        <= thr_d;
  end

  assign geom_o = geom_q;
  assign thr_o  = thr_q;

endmodule

`default_nettype wire

/* rtl/frts_front.sv */
// ----------------------------------------------------------------------------
// Front end
// Accepts pixel requests, tracks the window position, classifies each pixel
// into its template region and pushes the painted pixel into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frts_front
  import frts_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [PIX_W-1:0] red_i,
  input  wire logic [PIX_W-1:0] green_i,
  input  wire logic [PIX_W-1:0] blue_i,
  input  wire frts_geom_t       geom_i,
  input  wire logic             q_full_i,
  output logic                  push_o,
  output frts_item_t            item_o
);

  logic [DIM_W-1:0] col_q, col_d;
  logic [DIM_W-1:0] row_q, row_d;
  logic             accept;
  logic             in_tmpl, mouth, gap, eye, white, row_end, last;

  always_comb begin
    accept  = in_valid_i && !q_full_i;
    white   = (red_i == PIX_MAX);
    in_tmpl = (col_q > geom_i.cx1) && (col_q < geom_i.cx6) &&
              (row_q > geom_i.ry1) && (row_q < geom_i.ry4);
    mouth   = in_tmpl && (row_q >= geom_i.ry3);
    gap     = in_tmpl && !mouth &&
              ((row_q > geom_i.ry2) || ((col_q > geom_i.cx3) && (col_q < geom_i.cx4)));
    eye     = in_tmpl && !mouth && !gap;
    row_end = (col_q >= geom_i.col_last);
    last    = row_end && (row_q >= geom_i.row_last);

    item_o.pixel_x = POS_W'(geom_i.origin_x) + POS_W'(col_q);
    item_o.pixel_y = POS_W'(geom_i.origin_y) + POS_W'(row_q);
    item_o.red     = red_i;
    item_o.green   = mouth ? PIX_MAX : green_i;
    item_o.blue    = eye ? PIX_MAX : blue_i;
    item_o.last    = last;
    if (white && (eye || mouth)) begin
      item_o.delta = DELTA_PLUS;
    end else if (white && gap) begin
      item_o.delta = DELTA_MINUS;
    end else begin
      item_o.delta = DELTA_NONE;
    end

    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_q + DIM_W'(1);
      end else begin
        col_d = col_q + DIM_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign push_o     = accept;
  assign in_stall_o = q_full_i;

  // The window position restarts after its final pixel.
  a_window_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last) |=> (col_q == '0) && (row_q == '0))
    else $error("window position not cleared after last pixel");

endmodule

`default_nettype wire

/* rtl/frts_queue.sv */
// ----------------------------------------------------------------------------
// Pixel queue
// Short first-in first-out buffer between the front end and the scoring
// back end so that each side can stall on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frts_queue
  import frts_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire frts_item_t push_item_i,
  output logic      full_o,
  output logic      valid_o,
  input  wire logic pop_i,
  output frts_item_t head_o
);

  localparam int unsigned PTR_W = $clog2(QDEPTH);
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  frts_item_t       mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      count_q <= count_q + CNT_W'(push_i) - CNT_W'(pop_i);
    end
  end

  assign full_o  = (count_q == CNT_W'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QDEPTH))
    else $error("queue count beyond its depth");

  a_empty_ptrs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (rd_ptr_q == wr_ptr_q))
    else $error("queue pointers differ while empty");

endmodule

`default_nettype wire

/* rtl/frts_back.sv */
// ----------------------------------------------------------------------------
// Scoring back end
// Pops classified pixels, keeps the running template score and decides
// on the last pixel whether the score exceeds the face threshold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frts_back
  import frts_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        q_valid_i,
  input  wire frts_item_t                  head_i,
  output logic                             pop_o,
  input  wire logic [THR_W-1:0]            thr_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output frts_item_t                       out_item_o,
  output logic                             face_found_o,
  output logic signed [SCORE_O_W-1:0]      score_o
);

  logic signed [SCORE_W-1:0]   score_q, score_d, score_new;
  logic                        b1_valid_q;
  frts_item_t                  b1_item_q;
  logic signed [SCORE_W-1:0]   b1_score_q;
  logic                        out_valid_q;
  frts_item_t                  out_item_q;
  logic                        face_q;
  logic signed [SCORE_O_W-1:0] out_score_q;
  logic                        out_en, b1_en, pop;
  logic signed [SCORE_W+6:0]   score_ext, score_x100, thr_ext;
  logic                        over;

  always_comb begin
    out_en = !out_valid_q || !out_stall_i;
    b1_en  = !b1_valid_q || out_en;
    pop    = q_valid_i && b1_en;

    case (head_i.delta)
      DELTA_PLUS:  score_new = score_q + SCORE_W'(1);
      DELTA_MINUS: score_new = score_q - SCORE_W'(1);
      default:     score_new = score_q;
    endcase

    score_d = score_q;
    if (pop) begin
      score_d = head_i.last ? '0 : score_new;
    end

    // The score beats floor(13 * area / 100) exactly when 100 * score > 13 * area.
    score_ext  = (SCORE_W + 7)'(b1_score_q);
    score_x100 = (score_ext <<< 6) + (score_ext <<< 5) + (score_ext <<< 2);
    thr_ext    = $signed((SCORE_W + 7)'(thr_i));
    over       = score_x100 > thr_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_q     <= '0;
      b1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      score_q <= score_d;
      if (b1_en) begin
        b1_valid_q <= q_valid_i;
      end
      if (out_en) begin
        out_valid_q <= b1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b1_en) begin
      b1_item_q  <= head_i;
      b1_score_q <= score_new;
    end
    if (out_en) begin
      out_item_q  <= b1_item_q;
      out_score_q <= b1_score_q[SCORE_O_W-1:0];
      face_q      <= b1_item_q.last && over;
    end
  end

  assign pop_o        = pop;
  assign out_valid_o  = out_valid_q;
  assign out_item_o   = out_item_q;
  assign face_found_o = face_q;
  assign score_o      = out_score_q;

  a_score_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && head_i.last) |=> (score_q == '0))
    else $error("score not cleared after last pixel");

endmodule

`default_nettype wire

/* rtl/face_region_template_scorer_unit.sv */
// ----------------------------------------------------------------------------
// Face region template scorer
// Pixels of one window enter in raster order on the input channel. Each
// request carries red, green and blue; the output channel returns the
// pixel with its frame coordinates, region painting and running score.
// Both channels use valid and stall; a request moves on a rising edge with
// valid high and stall low. The configuration port writes the window origin
// and size and must only be used while no request is in flight.
// One request is taken per cycle while the input stall is low. After an
// input accept the front end registers the classified pixel into a
// two-entry queue, the back end adds it to the score, and the output
// register carries the face decision as output valid rises. The face
// threshold follows a size write through the bound, area and threshold
// registers. When the receiver stalls, the output register and the back
// stage hold; with requests back to back the queue then fills and the
// input stall rises. Reset clears the position counters, the score and all
// valid flags and loads the default window of 160 by 240 at origin zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module face_region_template_scorer_unit
  import frts_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [PIX_W-1:0]            red_in_i,
  input  wire logic [PIX_W-1:0]            green_in_i,
  input  wire logic [PIX_W-1:0]            blue_in_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [DIM_W-1:0]            cfg_wdata_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [POS_W-1:0]                 pixel_x_o,
  output logic [POS_W-1:0]                 pixel_y_o,
  output logic [PIX_W-1:0]                 red_out_o,
  output logic [PIX_W-1:0]                 green_out_o,
  output logic [PIX_W-1:0]                 blue_out_o,
  output logic                             last_pixel_o,
  output logic                             face_found_o,
  output logic signed [SCORE_O_W-1:0]      score_o
);

  frts_geom_t       geom;
  logic [THR_W-1:0] thr;
  logic             q_full, q_valid, push, pop;
  frts_item_t       push_item, head_item, out_item;

  frts_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .geom_o      (geom),
    .thr_o       (thr)
  );

  frts_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .red_i      (red_in_i),
    .green_i    (green_in_i),
    .blue_i     (blue_in_i),
    .geom_i     (geom),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (push_item)
  );

  frts_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (pop),
    .head_o      (head_item)
  );

  frts_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .head_i       (head_item),
    .pop_o        (pop),
    .thr_i        (thr),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item),
    .face_found_o (face_found_o),
    .score_o      (score_o)
  );

  assign pixel_x_o    = out_item.pixel_x;
  assign pixel_y_o    = out_item.pixel_y;
  assign red_out_o    = out_item.red;
  assign green_out_o  = out_item.green;
  assign blue_out_o   = out_item.blue;
  assign last_pixel_o = out_item.last;

endmodule

`default_nettype wire
